FILE: rtl/gn2d_pkg.sv
`default_nettype none
package gn2d_pkg;
  localparam int CELL_BITS_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] REG_SCALE = 2'd0;
  localparam logic [1:0] REG_BASE  = 2'd1;
  localparam logic [1:0] REG_GAIN  = 2'd2;

  typedef struct packed {
    logic [23:0] coord_scale;
    logic [31:0] offset_base;
    logic [31:0] gain;
  } gn2d_cfg_t;
endpackage
`default_nettype wire

FILE: rtl/gradient_noise_2d_top.sv
// channel | dir | tdata / tuser
// in_     | in  | tdata {entry_value,entry_index,coord_y,coord_x}, tuser op
// out_    | out | tdata noise_value
// cfg_    | in  | APB, coord_scale 0x0, offset_base 0x4, gain 0x8
// One item per cycle while the output is not stalled; each evaluate yields one result.
// The evaluate path runs through the five-stage fade multiplier chain and table reads.
// rst_n is synchronous; the permutation tables have no reset.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module gradient_noise_2d_top
  import gn2d_pkg::*;
#(
  parameter int CELL_BITS = CELL_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [79:0]  in_tdata,  // coord_x, coord_y, entry_index, entry_value
  input  wire logic         in_tuser,  // op
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata, // noise_value
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  gn2d_cfg_t cfg_r;
  logic [1:0] ridx;
  assign ridx = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coord_scale <= 24'd65536;
      cfg_r.offset_base <= '0;
      cfg_r.gain <= 32'd65536;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        REG_SCALE: cfg_r.coord_scale <= cfg_pwdata[23:0];
        REG_BASE: cfg_r.offset_base <= cfg_pwdata;
        REG_GAIN: cfg_r.gain <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_SCALE: cfg_prdata = {8'd0, cfg_r.coord_scale};
      REG_BASE: cfg_prdata = cfg_r.offset_base;
      REG_GAIN: cfg_prdata = cfg_r.gain;
      default: cfg_prdata = '0;
    endcase
  end

  logic en;
  assign en = out_tready || !out_tvalid;
  assign in_tready = en;

  gn2d_core #(.CELL_BITS(CELL_BITS), .FRAC_BITS(FRAC_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid),
    .in_op(in_tuser), .in_x(in_tdata[31:0]), .in_y(in_tdata[63:32]),
    .in_idx(in_tdata[71:64]), .in_val(in_tdata[79:72]), .cfg(cfg_r),
    .out_valid(out_tvalid), .out_data(out_tdata));
endmodule
`default_nettype wire

FILE: rtl/gn2d_ram.sv
`default_nettype none
module gn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/gn2d_fade.sv
`default_nettype none
// Fade polynomial 6t^6-15t^5+10t^4 over five registered stages; t is in [0,1).
module gn2d_fade
  import gn2d_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [FRAC_BITS-1:0] t,
  output logic      [FRAC_BITS:0]   f
);
  localparam int W = FRAC_BITS + 6;
  localparam int PW = 2 * W;

  logic signed [W-1:0] t1_r, t2_r;
  logic signed [W-1:0] a_r, b_r, tt_r, c_r, t3v_r, f4_r;
  logic signed [PW-1:0] pa, pb, pt, pt3, pf;

  assign pa = t1_r * a_r;
  assign pt = t1_r * t1_r;
  assign pb = t2_r * b_r;
  assign pt3 = tt_r * t2_r;
  assign pf = t3v_r * c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= W'({1'b0, t});
      a_r <= W'(6 * {1'b0, t}) - W'(15 << FRAC_BITS);
      t2_r <= t1_r;
      b_r <= W'(pa >>> FRAC_BITS) + W'(10 << FRAC_BITS);
      tt_r <= W'(pt >>> FRAC_BITS);
      c_r <= W'(pb >>> FRAC_BITS);
      t3v_r <= W'(pt3 >>> FRAC_BITS);
      f4_r <= W'(pf >>> FRAC_BITS);
      f <= (FRAC_BITS+1)'(f4_r);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/gn2d_core.sv
`default_nettype none
// Evaluation pipeline: scale, hash lookups, fade, gradients, lerps, gain, base add, clamp.
module gn2d_core
  import gn2d_pkg::*;
#(
  parameter int CELL_BITS = CELL_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic        in_op,
  input  wire logic [31:0] in_x,
  input  wire logic [31:0] in_y,
  input  wire logic [7:0]  in_idx,
  input  wire logic [7:0]  in_val,
  input  wire gn2d_cfg_t   cfg,
  output logic             out_valid,
  output logic [31:0]      out_data
);
  localparam int DEPTH = 1 << CELL_BITS;
  localparam int NST = 12;
  localparam int GW = FRAC_BITS + 4;
  localparam int SW = 64;
  localparam logic signed [GW-1:0] ONE = GW'(1 << FRAC_BITS);

  logic [NST-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid && in_op == OP_EVAL};
    end
  end
  assign out_valid = v_r[NST-1];

  // Stage 1: scale.
  logic signed [SW-1:0] sx1_r, sy1_r;
  logic signed [SW-1:0] px, py;
  assign px = SW'(signed'(in_x)) * SW'(signed'({1'b0, cfg.coord_scale}));
  assign py = SW'(signed'(in_y)) * SW'(signed'({1'b0, cfg.coord_scale}));
  always_ff @(posedge clk) begin
    if (en) begin
      sx1_r <= px >>> FRAC_BITS;
      sy1_r <= py >>> FRAC_BITS;
    end
  end

  logic [CELL_BITS-1:0] xi1, yi1;
  assign xi1 = sx1_r[FRAC_BITS +: CELL_BITS];
  assign yi1 = sy1_r[FRAC_BITS +: CELL_BITS];

  // Stage 2: first-level lookups; two tables keep one read port each.
  logic [7:0] pa2, pb2;
  logic [CELL_BITS-1:0] yi2_r;
  logic [FRAC_BITS-1:0] xf_r [2:3];
  logic [FRAC_BITS-1:0] yf_r [2:3];
  logic ld;
  assign ld = en && in_valid && in_op == OP_LOAD;

  // The second-level tables take each load one stage later, so an evaluate that
  // is already past the first lookup still sees the table as it was on acceptance.
  logic ld1_r;
  logic [7:0] idx1_r, val1_r;
  logic ld_h;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld1_r <= 1'b0;
    end else if (en) begin
      ld1_r <= in_valid && in_op == OP_LOAD;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r <= in_idx;
      val1_r <= in_val;
    end
  end
  assign ld_h = en && ld1_r;

  gn2d_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_p0 (.clk(clk), .we(ld),
    .waddr(CELL_BITS'(in_idx)), .wdata(in_val), .re(en), .raddr(xi1), .rdata(pa2));
  gn2d_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_p1 (.clk(clk), .we(ld),
    .waddr(CELL_BITS'(in_idx)), .wdata(in_val), .re(en), .raddr(xi1 + 1'b1),
    .rdata(pb2));

  logic [CELL_BITS-1:0] ia, ib;
  assign ia = CELL_BITS'(pa2) + yi2_r;
  assign ib = CELL_BITS'(pb2) + yi2_r;
  logic [7:0] haa, hab, hba, hbb;
  gn2d_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_h0 (.clk(clk), .we(ld_h),
    .waddr(CELL_BITS'(idx1_r)), .wdata(val1_r), .re(en), .raddr(ia), .rdata(haa));
  gn2d_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_h1 (.clk(clk), .we(ld_h),
    .waddr(CELL_BITS'(idx1_r)), .wdata(val1_r), .re(en), .raddr(ia + 1'b1),
    .rdata(hab));
  gn2d_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_h2 (.clk(clk), .we(ld_h),
    .waddr(CELL_BITS'(idx1_r)), .wdata(val1_r), .re(en), .raddr(ib), .rdata(hba));
  gn2d_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_h3 (.clk(clk), .we(ld_h),
    .waddr(CELL_BITS'(idx1_r)), .wdata(val1_r), .re(en), .raddr(ib + 1'b1),
    .rdata(hbb));

  always_ff @(posedge clk) begin
    if (en) begin
      yi2_r <= yi1;
      xf_r[2] <= sx1_r[FRAC_BITS-1:0];
      yf_r[2] <= sy1_r[FRAC_BITS-1:0];
      xf_r[3] <= xf_r[2];
      yf_r[3] <= yf_r[2];
    end
  end

  // Fades start at stage 2 and land at stage 7.
  logic [FRAC_BITS:0] u7, v7;
  gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fu (.clk(clk), .en(en), .t(xf_r[2]), .f(u7));
  gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fv (.clk(clk), .en(en), .t(yf_r[2]), .f(v7));

  function automatic logic signed [GW-1:0] grad(input logic [1:0] h,
      input logic signed [GW-1:0] x, input logic signed [GW-1:0] y);
    case (h)
      2'd0: grad = x + y;
      2'd1: grad = -x + y;
      2'd2: grad = x - y;
      default: grad = -x - y;
    endcase
  endfunction

  // Stage 4: gradients (hash data valid at stage 4 input).
  logic signed [GW-1:0] xs, ys, g0_r [4:7], g1_r [4:7], g2_r [4:7], g3_r [4:7];
  assign xs = GW'({1'b0, xf_r[3]});
  assign ys = GW'({1'b0, yf_r[3]});
  always_ff @(posedge clk) begin
    if (en) begin
      g0_r[4] <= grad(haa[1:0], xs, ys);
      g1_r[4] <= grad(hba[1:0], xs - ONE, ys);
      g2_r[4] <= grad(hab[1:0], xs, ys - ONE);
      g3_r[4] <= grad(hbb[1:0], xs - ONE, ys - ONE);
      for (int i = 5; i <= 7; i++) begin
        g0_r[i] <= g0_r[i-1];
        g1_r[i] <= g1_r[i-1];
        g2_r[i] <= g2_r[i-1];
        g3_r[i] <= g3_r[i-1];
      end
    end
  end

  // Stage 8: horizontal lerps.
  localparam int PW = 2 * GW + 2;
  logic signed [PW-1:0] m0, m1;
  logic signed [GW-1:0] r0_r, r1_r;
  logic [FRAC_BITS:0] v8_r;
  assign m0 = PW'(signed'({1'b0, u7})) * PW'(g1_r[7] - g0_r[7]);
  assign m1 = PW'(signed'({1'b0, u7})) * PW'(g3_r[7] - g2_r[7]);
  always_ff @(posedge clk) begin
    if (en) begin
      r0_r <= g0_r[7] + GW'(m0 >>> FRAC_BITS);
      r1_r <= g2_r[7] + GW'(m1 >>> FRAC_BITS);
      v8_r <= v7;
    end
  end

  // Stage 9: vertical lerp.
  logic signed [PW-1:0] m2;
  logic signed [GW-1:0] n9_r;
  assign m2 = PW'(signed'({1'b0, v8_r})) * PW'(r1_r - r0_r);
  always_ff @(posedge clk) begin
    if (en) begin
      n9_r <= r0_r + GW'(m2 >>> FRAC_BITS);
    end
  end

  // Stage 10: gain product. Stage 11: base add. Stage 12: clamp.
  logic signed [63:0] gp_r, sum_r;
  always_ff @(posedge clk) begin
    if (en) begin
      gp_r <= (64'(signed'(cfg.gain)) * 64'(n9_r)) >>> FRAC_BITS;
      sum_r <= gp_r + 64'(signed'(cfg.offset_base));
      if (sum_r > 64'sd2147483647) begin
        out_data <= 32'h7fff_ffff;
      end else if (sum_r < -64'sd2147483648) begin
        out_data <= 32'h8000_0000;
      end else begin
        out_data <= sum_r[31:0];
      end
    end
  end

  logic unused;
  assign unused = ^{sx1_r[SW-1:FRAC_BITS+CELL_BITS], sy1_r[SW-1:FRAC_BITS+CELL_BITS]};

`ifndef NO_ASSERTIONS
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en && in_valid && in_op == OP_LOAD) |=> !v_r[0]) else $error("load made result");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(en) |-> $stable(v_r)) else $error("pipe moved in stall");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(en) && out_valid) |-> $stable(out_data)) else $error("out changed in stall");
`endif
endmodule
`default_nettype wire
